[sv/rssi_window_punch_qualifier_top_assert.svh]
// Assertion macros shared by the punch qualifier RTL.
// Every macro expects clk_i and the active-low reset rst_ni to be in scope.
`ifndef RSSI_WINDOW_PUNCH_QUALIFIER_TOP_ASSERT_SVH
`define RSSI_WINDOW_PUNCH_QUALIFIER_TOP_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define RWPQ_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("rwpq: invariant violated");

// A consequence that must hold in the same cycle as its antecedent.
`define RWPQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rwpq: implication violated");

// A consequence that must hold in the cycle after its antecedent.
`define RWPQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rwpq: next-cycle implication violated");

`endif

[sv/rwpq_pkg.sv]
// Types and constants of the RSSI window punch qualifier.
// No dependencies; the front end, queue, back end and top level import this package.
`default_nettype none

package rwpq_pkg;

  // Result outcome codes.
  typedef enum logic [2:0] {
    OC_BAD_LEN   = 3'd0,
    OC_HELD_OFF  = 3'd1,
    OC_SCANNING  = 3'd2,
    OC_SPAM      = 3'd3,
    OC_NEW_RACE  = 3'd4,
    OC_LOGGED    = 3'd5
  } outcome_e;

  // Race phase.
  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_RACING   = 2'd1,
    PH_FINISHED = 2'd2
  } phase_e;

  // Receiver command.
  typedef enum logic [1:0] {
    RX_NONE = 2'd0,
    RX_ON   = 2'd1,
    RX_OFF  = 2'd2
  } rx_cmd_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_WINDOW_LENGTH  = 3'd0,
    CFG_HITS_NEEDED    = 3'd1,
    CFG_HOLD_OFF_MS    = 3'd2,
    CFG_CLEAR_STATION  = 3'd3,
    CFG_CHECK_STATION  = 3'd4,
    CFG_START_STATION  = 3'd5,
    CFG_FINISH_STATION = 3'd6
  } cfg_idx_e;

  // Back end sequencer states.
  typedef enum logic {
    BK_LOAD   = 1'b0,
    BK_DECIDE = 1'b1
  } bk_state_e;

  // Frame geometry and fixed limits.
  localparam logic [6:0]        FRAME_LEN_OK   = 7'd6;
  localparam logic signed [7:0] DEFAULT_THR    = -8'sd50;
  localparam logic [11:0]       STD_ID_MIN     = 12'd31;
  localparam logic [7:0]        DEF_WINDOW     = 8'd5;
  localparam logic [7:0]        DEF_HITS       = 8'd3;
  localparam int unsigned       QUEUE_DEPTH    = 2;

  // Configuration register bank.
  typedef struct packed {
    logic [7:0]  window_length;
    logic [7:0]  hits_needed;
    logic [15:0] hold_off_ms;
    logic [11:0] clear_station;
    logic [11:0] check_station;
    logic [11:0] start_station;
    logic [11:0] finish_station;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    window_length:  8'd5,
    hits_needed:    8'd3,
    hold_off_ms:    16'd0,
    clear_station:  12'd0,
    check_station:  12'd1,
    start_station:  12'd2,
    finish_station: 12'd3
  };

  // A classified frame as it travels from the front end to the back end.
  typedef struct packed {
    logic              len_ok;
    logic [11:0]       station;
    logic signed [7:0] thr;
    logic [7:0]        magnitude;
    logic              hit;
    logic [31:0]       now_ms;
  } queue_item_t;

  // One result item.
  typedef struct packed {
    outcome_e          outcome;
    logic [11:0]       station;
    logic [5:0]        hit_count;
    logic signed [7:0] threshold_used;
    logic [7:0]        strength_magnitude;
    phase_e            race_phase;
    rx_cmd_e           receiver_command;
    logic              protocol_switch;
  } result_t;

endpackage

`default_nettype wire

[sv/rwpq_intf.sv]
// Request channel interfaces of the punch qualifier: frames in, results out, config writes.
// Depends on nothing but the language; widths are those of the frame and result fields.
`default_nettype none

// Received frame channel.
interface rwpq_in_if;
  logic              valid;
  logic              ready;
  logic [6:0]        frame_length;
  logic [7:0]        first_byte;
  logic [7:0]        second_byte;
  logic [7:0]        sixth_byte;
  logic signed [7:0] signal_strength;
  logic [31:0]       now_ms;

  modport source (output valid, frame_length, first_byte, second_byte, sixth_byte,
                  signal_strength, now_ms, input ready);
  modport sink   (input valid, frame_length, first_byte, second_byte, sixth_byte,
                  signal_strength, now_ms, output ready);
endinterface

// Result channel.
interface rwpq_out_if;
  logic              valid;
  logic              ready;
  logic [2:0]        outcome;
  logic [11:0]       station;
  logic [5:0]        hit_count;
  logic signed [7:0] threshold_used;
  logic [7:0]        strength_magnitude;
  logic [1:0]        race_phase;
  logic [1:0]        receiver_command;
  logic              protocol_switch;

  modport source (output valid, outcome, station, hit_count, threshold_used,
                  strength_magnitude, race_phase, receiver_command, protocol_switch,
                  input ready);
  modport sink   (input valid, outcome, station, hit_count, threshold_used,
                  strength_magnitude, race_phase, receiver_command, protocol_switch,
                  output ready);
endinterface

// Configuration write channel.
interface rwpq_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reg_index;
  logic [15:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

[sv/rwpq_front.sv]
// Front end of the punch qualifier: accepts frames and classifies them for the queue.
// Depends on rwpq_pkg and the frame channel interface.
`default_nettype none

module rwpq_front
  import rwpq_pkg::*;
(
  rwpq_in_if.sink     in_i,
  input  logic [11:0] clear_station_i,
  output logic        push_valid_o,
  input  logic        push_ready_i,
  output queue_item_t push_item_o
);

  logic [11:0]       station;
  logic signed [7:0] thr;

  // The station id is the first byte followed by the high nibble of the second.
  assign station = {in_i.first_byte, in_i.second_byte[7:4]};

  // The clear station carries its own limit, the negated sixth byte.
  assign thr = (station == clear_station_i) ? 8'(8'd0 - in_i.sixth_byte) : DEFAULT_THR;

  // Classification needs no state, so a frame goes straight into the queue.
  always_comb begin
    push_item_o.len_ok    = (in_i.frame_length == FRAME_LEN_OK);
    push_item_o.station   = station;
    push_item_o.thr       = thr;
    push_item_o.magnitude = 8'(8'd0 - in_i.signal_strength);
    push_item_o.hit       = (in_i.signal_strength >= thr);
    push_item_o.now_ms    = in_i.now_ms;
  end

  assign push_valid_o = in_i.valid;
  assign in_i.ready   = push_ready_i;

endmodule

`default_nettype wire

[sv/rwpq_queue.sv]
// Short queue of classified frames between the front end and the back end.
// Depends on rwpq_pkg and the assertion macro header.
`default_nettype none
`include "rssi_window_punch_qualifier_top_assert.svh"

module rwpq_queue
  import rwpq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_valid_i,
  output logic        push_ready_o,
  input  queue_item_t push_item_i,
  output logic        pop_valid_o,
  input  logic        pop_ready_i,
  output queue_item_t pop_item_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  queue_item_t         entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = entry_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
    end
    if (push && !pop) begin
      cnt_d = CNT_W'(cnt_q + 1'b1);
    end else if (pop && !push) begin
      cnt_d = CNT_W'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage carries payload only.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

  `RWPQ_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CNT_W'(QUEUE_DEPTH))
  `RWPQ_ASSERT_NXT(a_push_grows, push && !pop, cnt_q == CNT_W'($past(cnt_q) + 1'b1))
  `RWPQ_ASSERT_NXT(a_pop_shrinks, pop && !push, cnt_q == CNT_W'($past(cnt_q) - 1'b1))

endmodule

`default_nettype wire

[sv/rwpq_back.sv]
// Back end of the punch qualifier: hold-off, hit history, window count and punch decision.
// Depends on rwpq_pkg, the result channel interface and the assertion macro header.
`default_nettype none
`include "rssi_window_punch_qualifier_top_assert.svh"

module rwpq_back
  import rwpq_pkg::*;
#(
  parameter int unsigned HISTORY_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        pop_valid_i,
  output logic        pop_ready_o,
  input  queue_item_t pop_item_i,
  rwpq_out_if.source  out_o
);

  localparam int unsigned CNT_W = $clog2(HISTORY_BITS + 1);
  localparam logic [7:0]  HB8   = 8'(HISTORY_BITS);

  bk_state_e               state_q, state_d;
  queue_item_t             st_item_q, st_item_d;
  logic                    st_bad_q, st_bad_d;
  logic                    st_held_q, st_held_d;
  logic                    scan_vld_q, scan_vld_d;
  logic [11:0]             scan_id_q, scan_id_d;
  logic [HISTORY_BITS-1:0] hist_q, hist_d, hist_base;
  logic                    held_vld_q, held_vld_d;
  logic [11:0]             held_id_q, held_id_d;
  logic [31:0]             punch_time_q, punch_time_d;
  logic                    log_vld_q, log_vld_d;
  logic [11:0]             log_id_q, log_id_d;
  phase_e                  phase_q, phase_d;
  logic                    out_vld_q, out_vld_d;
  result_t                 out_q, out_d;

  logic                    held_now;
  logic [7:0]              w_eff, need_eff;
  logic [HISTORY_BITS-1:0] wmask;
  logic [CNT_W-1:0]        cnt;
  logic                    enough, standard, spam, out_free, punch;

  // Hold-off: same station as the last punch and the elapsed time still short.
  assign held_now = held_vld_q && (pop_item_i.station == held_id_q) &&
                    ((pop_item_i.now_ms - punch_time_q) < {16'd0, cfg_i.hold_off_ms});

  // Effective window and hit requirement, with their fall-back values.
  assign w_eff    = ((cfg_i.window_length == 8'd0) || (cfg_i.window_length > HB8)) ?
                    DEF_WINDOW : cfg_i.window_length;
  assign need_eff = (cfg_i.hits_needed == 8'd0) ? DEF_HITS : cfg_i.hits_needed;

  // Window mask over the newest history bits.
  always_comb begin
    for (int unsigned i = 0; i < HISTORY_BITS; i++) begin
      wmask[i] = (8'(i) < w_eff);
    end
  end

  assign cnt    = CNT_W'($countones(hist_q & wmask));
  assign enough = (9'(cnt) >= {1'b0, need_eff});

  // Spam: a standard station punched again right after being logged.
  assign standard = (st_item_q.station >= STD_ID_MIN) ||
                    (st_item_q.station == cfg_i.check_station) ||
                    (st_item_q.station == cfg_i.start_station);
  assign spam     = standard && log_vld_q && (st_item_q.station == log_id_q);

  assign out_free    = !out_vld_q || out_o.ready;
  assign pop_ready_o = (state_q == BK_LOAD);

  assign hist_base = (scan_vld_q && (pop_item_i.station == scan_id_q)) ? hist_q : '0;

  // Two-step sequencer: load and shift, then count and decide.
  always_comb begin
    state_d      = state_q;
    st_item_d    = st_item_q;
    st_bad_d     = st_bad_q;
    st_held_d    = st_held_q;
    scan_vld_d   = scan_vld_q;
    scan_id_d    = scan_id_q;
    hist_d       = hist_q;
    held_vld_d   = held_vld_q;
    held_id_d    = held_id_q;
    punch_time_d = punch_time_q;
    log_vld_d    = log_vld_q;
    log_id_d     = log_id_q;
    phase_d      = phase_q;
    out_vld_d    = out_vld_q && !out_o.ready;
    out_d        = out_q;
    punch        = 1'b0;

    case (state_q)
      BK_LOAD: begin
        if (pop_valid_i) begin
          st_item_d = pop_item_i;
          st_bad_d  = !pop_item_i.len_ok;
          st_held_d = pop_item_i.len_ok && held_now;
          // A scanning frame restarts the history on a new station and shifts in.
          if (pop_item_i.len_ok && !held_now) begin
            scan_vld_d = 1'b1;
            scan_id_d  = pop_item_i.station;
            hist_d     = {hist_base[HISTORY_BITS-2:0], pop_item_i.hit};
          end
          state_d = BK_DECIDE;
        end
      end
      BK_DECIDE: begin
        if (out_free) begin
          out_d.outcome            = OC_SCANNING;
          out_d.station            = st_item_q.station;
          out_d.hit_count          = '0;
          out_d.threshold_used     = st_item_q.thr;
          out_d.strength_magnitude = st_item_q.magnitude;
          out_d.receiver_command   = RX_NONE;
          out_d.protocol_switch    = 1'b0;
          if (st_bad_q) begin
            out_d.outcome        = OC_BAD_LEN;
            out_d.threshold_used = '0;
          end else if (st_held_q) begin
            out_d.outcome = OC_HELD_OFF;
          end else begin
            out_d.hit_count = 6'(cnt);
            if (enough) begin
              // Punch: start the hold-off and restart the history.
              punch        = 1'b1;
              held_vld_d   = 1'b1;
              held_id_d    = st_item_q.station;
              punch_time_d = st_item_q.now_ms;
              hist_d       = '0;
              if (spam) begin
                out_d.outcome = OC_SPAM;
              end else if (st_item_q.station == cfg_i.clear_station) begin
                out_d.outcome = OC_NEW_RACE;
                log_vld_d     = 1'b1;
                log_id_d      = st_item_q.station;
                if (phase_q != PH_RACING) begin
                  phase_d                = PH_RACING;
                  out_d.receiver_command = RX_ON;
                end
              end else begin
                out_d.outcome = OC_LOGGED;
                log_vld_d     = 1'b1;
                log_id_d      = st_item_q.station;
                if ((st_item_q.station == cfg_i.finish_station) && (phase_q == PH_RACING)) begin
                  phase_d                = PH_FINISHED;
                  out_d.receiver_command = RX_OFF;
                  out_d.protocol_switch  = 1'b1;
                end
              end
            end
          end
          out_d.race_phase = phase_d;
          out_vld_d        = 1'b1;
          state_d          = BK_LOAD;
        end
      end
      default: begin
        state_d = BK_LOAD;
      end
    endcase
  end

  // Control and station state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BK_LOAD;
      scan_vld_q   <= 1'b0;
      scan_id_q    <= '0;
      hist_q       <= '0;
      held_vld_q   <= 1'b0;
      held_id_q    <= '0;
      punch_time_q <= '0;
      log_vld_q    <= 1'b0;
      log_id_q     <= '0;
      phase_q      <= PH_IDLE;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      scan_vld_q   <= scan_vld_d;
      scan_id_q    <= scan_id_d;
      hist_q       <= hist_d;
      held_vld_q   <= held_vld_d;
      held_id_q    <= held_id_d;
      punch_time_q <= punch_time_d;
      log_vld_q    <= log_vld_d;
      log_id_q     <= log_id_d;
      phase_q      <= phase_d;
      out_vld_q    <= out_vld_d;
    end
  end

  // Stage and result payload.
  always_ff @(posedge clk_i) begin
    st_item_q <= st_item_d;
    st_bad_q  <= st_bad_d;
    st_held_q <= st_held_d;
    out_q     <= out_d;
  end

  // Result channel.
  assign out_o.valid              = out_vld_q;
  assign out_o.outcome            = out_q.outcome;
  assign out_o.station            = out_q.station;
  assign out_o.hit_count          = out_q.hit_count;
  assign out_o.threshold_used     = out_q.threshold_used;
  assign out_o.strength_magnitude = out_q.strength_magnitude;
  assign out_o.race_phase         = out_q.race_phase;
  assign out_o.receiver_command   = out_q.receiver_command;
  assign out_o.protocol_switch    = out_q.protocol_switch;

  `RWPQ_ASSERT_NXT(a_punch_clears_hist, punch, hist_q == '0)
  `RWPQ_ASSERT_NXT(a_finish_sticks, phase_q == PH_FINISHED, phase_q != PH_IDLE)
  `RWPQ_ASSERT_NXT(a_pop_then_decide, pop_valid_i && pop_ready_o, state_q == BK_DECIDE)
  `RWPQ_ASSERT_IMP(a_rx_on_racing, out_vld_q && (out_q.receiver_command == RX_ON),
                   out_q.race_phase == PH_RACING)

endmodule

`default_nettype wire

[sv/rssi_window_punch_qualifier_top.sv]
// Top level of the RSSI window punch qualifier: configuration bank, front end, queue, back end.
// Depends on rwpq_pkg, rwpq_intf, rwpq_front, rwpq_queue and rwpq_back.
`default_nettype none

// The block takes one received radio frame per request and returns one result per frame.
// A frame is taken in the cycle it is offered while the two-entry queue has room; the back
// end then does the hold-off check and history shift, then the window count and punch
// decision, and loads no new frame until that decision is made. The result sits in an
// output register; while it waits to be taken, frames still enter the queue and the back
// end loads the next one, but that frame's decision waits until the register is free.
// Configuration writes are always accepted and must only be made while no frame is in flight.

module rssi_window_punch_qualifier_top
  import rwpq_pkg::*;
#(
  parameter int unsigned HISTORY_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rwpq_cfg_if.sink   cfg_i,
  rwpq_in_if.sink    in_i,
  rwpq_out_if.source out_o
);

  cfg_t        cfg_q, cfg_d;
  logic        push_valid, push_ready;
  queue_item_t push_item;
  logic        pop_valid, pop_ready;
  queue_item_t pop_item;

  // Configuration register bank; writes beyond the list are dropped.
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.reg_index))
        CFG_WINDOW_LENGTH:  cfg_d.window_length  = cfg_i.wdata[7:0];
        CFG_HITS_NEEDED:    cfg_d.hits_needed    = cfg_i.wdata[7:0];
        CFG_HOLD_OFF_MS:    cfg_d.hold_off_ms    = cfg_i.wdata;
        CFG_CLEAR_STATION:  cfg_d.clear_station  = cfg_i.wdata[11:0];
        CFG_CHECK_STATION:  cfg_d.check_station  = cfg_i.wdata[11:0];
        CFG_START_STATION:  cfg_d.start_station  = cfg_i.wdata[11:0];
        CFG_FINISH_STATION: cfg_d.finish_station = cfg_i.wdata[11:0];
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Frame classification.
  rwpq_front u_front (
    .in_i            (in_i),
    .clear_station_i (cfg_q.clear_station),
    .push_valid_o    (push_valid),
    .push_ready_i    (push_ready),
    .push_item_o     (push_item)
  );

  // Queue between the two halves.
  rwpq_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  // Stateful qualification and result register.
  rwpq_back #(
    .HISTORY_BITS (HISTORY_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
